// ----- src/gini_best_boolean_split_defines.svh -----
// Assertion macros for the Gini split selector.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef GINI_BEST_BOOLEAN_SPLIT_DEFINES_SVH
`define GINI_BEST_BOOLEAN_SPLIT_DEFINES_SVH
`ifndef SYNTH
`define GBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define GBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- src/gbs_pkg.sv -----
// Shared constants and the result struct of the Gini split selector.
// No dependencies.
`timescale 1ns / 1ps
package gbs_pkg;
    localparam int FRAC_W     = 32;  // Q0.32 fraction bits
    localparam int IMP_W      = 30;  // p(1-p)/2 never exceeds 2^29
    localparam int GAIN_W     = 32;
    localparam int FEAT_IDX_W = 5;
    localparam int CNT_OUT_W  = 17;
    localparam int INPUT_W    = 32;

    typedef struct packed {
        logic [FEAT_IDX_W-1:0] best_feature;
        logic                  found;
        logic                  all_invalid;
        logic [GAIN_W-1:0]     best_gain;
    } split_t;
endpackage

// ----- src/gini_best_boolean_split.sv -----
// Gini best boolean split selector, top level.
// Input channel: one row per beat (feature_bits, class_label, last_row) on
// in_valid/in_stall. Output channel: one result beat per data set on
// out_valid/out_stall, issued only for a row with last_row set.
// cfg_wr_en/cfg_wr_data write candidate_mask (reset all ones); write only
// while idle.
// Rows that are not last are taken one per cycle while in_stall is low. After a
// last row, in_stall stays high while scoring runs: every feature lane computes
// its two child impurities and the weighted sum with three bit-serial divisions
// in series (CW = counter width, 17 by default), then the merge scans the lanes
// one per cycle (NL = min(NUM_FEATURES,32) lanes). in_stall drops in the same
// cycle in which out_valid rises. A stalled result holds; rows of the next data
// set are taken meanwhile, but after its last row in_stall stays high until the
// held result has left.
// Reset clears all counts, the FSM and out_valid, and sets the mask to all ones.
// Depends on gbs_pkg, gbs_lane, gbs_gini, gbs_div, gbs_merge and the defines header.
`timescale 1ns / 1ps
`include "gini_best_boolean_split_defines.svh"
module gini_best_boolean_split #(
    parameter int NUM_FEATURES = 32,
    parameter int MAX_ROWS     = 65536
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [gbs_pkg::INPUT_W-1:0]    feature_bits,
    input  logic                           class_label,
    input  logic                           last_row,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [gbs_pkg::FEAT_IDX_W-1:0] best_feature,
    output logic                           found,
    output logic                           all_invalid,
    output logic [gbs_pkg::GAIN_W-1:0]     best_gain,
    output logic [gbs_pkg::CNT_OUT_W-1:0]  rows_seen,
    output logic [gbs_pkg::CNT_OUT_W-1:0]  ones_seen,
    output logic                           is_pure,
    input  logic                           cfg_wr_en,
    input  logic [gbs_pkg::INPUT_W-1:0]    cfg_wr_data
);
    import gbs_pkg::*;

    localparam int NL = (NUM_FEATURES < INPUT_W) ? NUM_FEATURES : INPUT_W;
    localparam int CW = $clog2(MAX_ROWS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCORE, S_MERGE, S_OUT} state_t;

    state_t             state_reg;
    logic               start_reg;
    logic [CW-1:0]      row_total_reg, ones_total_reg;
    logic [INPUT_W-1:0] mask_reg;
    logic [IMP_W-1:0]   parent_reg;
    logic               parent_ok_reg;
    logic               out_valid_reg;
    split_t             res_reg;
    logic [CNT_OUT_W-1:0] rows_reg, ones_reg, rows_hold_reg, ones_hold_reg;
    logic               pure_reg, pure_hold_reg;

    logic               in_beat, score_done, merge_done;
    logic               par_done;
    logic [IMP_W-1:0]   par_imp;
    logic [NL-1:0]      lane_rdy, lane_ok;
    logic [GAIN_W-1:0]  lane_w [NL];
    split_t             merge_best;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_beat    = in_valid && !in_stall;
    assign score_done = (state_reg == S_SCORE) && !start_reg && parent_ok_reg && (&lane_rdy);

    for (genvar i = 0; i < NL; i++)
    begin : g_lane
        gbs_lane #(.CW(CW), .MAX_ROWS(MAX_ROWS)) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .row_beat   (in_beat),
            .feat_bit   (feature_bits[i]),
            .cls_bit    (class_label),
            .clr        (score_done),
            .start      (start_reg),
            .n_total    (row_total_reg),
            .ones_total (ones_total_reg),
            .ready      (lane_rdy[i]),
            .split_ok   (lane_ok[i]),
            .w          (lane_w[i])
        );
    end

    gbs_gini #(.CW(CW)) u_parent (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .c     (ones_total_reg),
        .n     (row_total_reg),
        .done  (par_done),
        .imp   (par_imp)
    );

    gbs_merge #(.NL(NL)) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (score_done),
        .cand     (mask_reg[NL-1:0]),
        .split_ok (lane_ok),
        .w        (lane_w),
        .parent   (parent_reg),
        .done     (merge_done),
        .best     (merge_best)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '1;
        end
        else if (cfg_wr_en)
        begin
            mask_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_total_reg  <= '0;
            ones_total_reg <= '0;
        end
        else if (score_done)
        begin
            row_total_reg  <= '0;
            ones_total_reg <= '0;
        end
        else if (in_beat)
        begin
            if (row_total_reg < CW'(MAX_ROWS))
                row_total_reg <= row_total_reg + 1'b1;
            if (class_label && ones_total_reg < CW'(MAX_ROWS))
                ones_total_reg <= ones_total_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            parent_reg    <= '0;
            parent_ok_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
            rows_reg      <= '0;
            ones_reg      <= '0;
            pure_reg      <= 1'b0;
            rows_hold_reg <= '0;
            ones_hold_reg <= '0;
            pure_hold_reg <= 1'b0;
        end
        else
        begin
            start_reg <= (state_reg == S_IDLE) && in_beat && last_row;
            // in S_OUT the case below decides out_valid
            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;
            if (start_reg)
                parent_ok_reg <= 1'b0;
            else if (par_done)
            begin
                parent_reg    <= par_imp;
                parent_ok_reg <= 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_beat && last_row)
                        state_reg <= S_SCORE;
                end
                S_SCORE:
                begin
                    if (score_done)
                    begin
                        rows_hold_reg <= CNT_OUT_W'(row_total_reg);
                        ones_hold_reg <= CNT_OUT_W'(ones_total_reg);
                        pure_hold_reg <= (ones_total_reg == '0) ||
                                         (ones_total_reg == row_total_reg);
                        state_reg     <= S_MERGE;
                    end
                end
                S_MERGE:
                begin
                    if (merge_done)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        res_reg       <= merge_best;
                        rows_reg      <= rows_hold_reg;
                        ones_reg      <= ones_hold_reg;
                        pure_reg      <= pure_hold_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign best_feature = res_reg.best_feature;
    assign found        = res_reg.found;
    assign all_invalid  = res_reg.all_invalid;
    assign best_gain    = res_reg.best_gain;
    assign rows_seen    = rows_reg;
    assign ones_seen    = ones_reg;
    assign is_pure      = pure_reg;

    `GBS_ASSERT_NXT(a_last_starts, clk, rst_n, in_beat && last_row,
        (state_reg == S_SCORE) && start_reg, "last row did not start scoring")
    `GBS_ASSERT_IMP(a_merge_in_state, clk, rst_n, merge_done,
        state_reg == S_MERGE, "merge finished outside merge state")
    `GBS_ASSERT_IMP(a_counts_cleared, clk, rst_n, state_reg == S_MERGE,
        (row_total_reg == '0) && (ones_total_reg == '0), "counts not cleared after scoring")
    `GBS_ASSERT_IMP(a_ones_le_rows, clk, rst_n, 1'b1,
        ones_total_reg <= row_total_reg, "class-one count exceeds row count")
endmodule

// ----- src/gbs_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by gbs_gini and gbs_lane.
`timescale 1ns / 1ps
module gbs_div #(
    parameter int DW = 8,
    parameter int VW = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CNTW = $clog2(DW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [VW-1:0]   rem_reg;
    logic [VW-1:0]   dvs_reg;
    logic [DW-1:0]   dq_reg;
    logic [VW:0]     rem_sh;
    logic [VW:0]     rem_sub;
    logic            ge;

    assign rem_sh  = {rem_reg, dq_reg[DW-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNTW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dq_reg  <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
            dq_reg  <= {dq_reg[DW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;
endmodule

// ----- src/gbs_gini.sv -----
// Gini impurity p(1-p)/2 in Q0.32 for c ones out of n rows.
// Depends on gbs_pkg and gbs_div.
`timescale 1ns / 1ps
module gbs_gini #(
    parameter int CW = 17
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [CW-1:0]             c,
    input  logic [CW-1:0]             n,
    output logic                      done,
    output logic [gbs_pkg::IMP_W-1:0] imp
);
    import gbs_pkg::*;

    typedef enum logic [1:0] {G_IDLE, G_DIV, G_MUL} gstate_t;

    gstate_t              state_reg;
    logic                 zero_reg;
    logic                 done_reg;
    logic [IMP_W-1:0]     imp_reg;
    logic [CW-1:0]        c_cl;
    logic                 div_done;
    logic [CW+FRAC_W-1:0] q;
    logic [FRAC_W:0]      p;
    logic [FRAC_W-1:0]    p_neg;
    logic [2*FRAC_W-1:0]  prod;

    assign c_cl = (c > n) ? n : c;

    gbs_div #(.DW(CW + FRAC_W), .VW(CW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dividend ({c_cl, {FRAC_W{1'b0}}}),
        .divisor  (n),
        .done     (div_done),
        .quotient (q)
    );

    assign p     = q[FRAC_W:0];
    assign p_neg = ~p[FRAC_W-1:0] + 1'b1;
    assign prod  = (2*FRAC_W)'(p[FRAC_W-1:0]) * (2*FRAC_W)'(p_neg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
            done_reg  <= 1'b0;
            zero_reg  <= 1'b0;
            imp_reg   <= '0;
        end
        else
        begin
            done_reg <= (state_reg == G_MUL);
            unique case (state_reg)
                G_IDLE:
                begin
                    if (start)
                    begin
                        zero_reg  <= (n == '0);
                        state_reg <= G_DIV;
                    end
                end
                G_DIV:
                begin
                    if (div_done)
                        state_reg <= G_MUL;
                end
                G_MUL:
                begin
                    // p of zero or one gives zero impurity
                    if (zero_reg || p[FRAC_W] || (p == '0))
                        imp_reg <= '0;
                    else
                        imp_reg <= prod[FRAC_W+1+IMP_W-1:FRAC_W+1];
                    state_reg <= G_IDLE;
                end
                default: state_reg <= G_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign imp  = imp_reg;
endmodule

// ----- src/gbs_lane.sv -----
// One feature lane: set-side counters and the weighted child impurity.
// Depends on gbs_pkg, gbs_gini and gbs_div.
`timescale 1ns / 1ps
module gbs_lane #(
    parameter int CW       = 17,
    parameter int MAX_ROWS = 65536
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       row_beat,
    input  logic                       feat_bit,
    input  logic                       cls_bit,
    input  logic                       clr,
    input  logic                       start,
    input  logic [CW-1:0]              n_total,
    input  logic [CW-1:0]              ones_total,
    output logic                       ready,
    output logic                       split_ok,
    output logic [gbs_pkg::GAIN_W-1:0] w
);
    import gbs_pkg::*;

    localparam int PW = CW + IMP_W;
    localparam int SW = PW + 1;

    typedef enum logic [2:0] {L_IDLE, L_G1, L_G0, L_M1, L_M0, L_SUM, L_DIV} lstate_t;

    lstate_t          state_reg;
    logic [CW-1:0]    n1_reg, c1_reg;
    logic [CW-1:0]    n0, c0;
    logic [IMP_W-1:0] imp1_reg, imp0_reg;
    logic [PW-1:0]    prod1_reg, prod0_reg;
    logic             ready_reg, ok_reg;
    logic [GAIN_W-1:0] w_reg;
    logic             g_start, g_done, div_start, div_done;
    logic [CW-1:0]    g_c, g_n;
    logic [IMP_W-1:0] g_imp;
    logic [SW-1:0]    q;

    assign n0 = (n_total > n1_reg) ? n_total - n1_reg : '0;
    assign c0 = (ones_total > c1_reg) ? ones_total - c1_reg : '0;

    // set side first, clear side when the set side finishes
    assign g_start   = (state_reg == L_IDLE && start) || (state_reg == L_G1 && g_done);
    assign g_c       = (state_reg == L_G1) ? c0 : c1_reg;
    assign g_n       = (state_reg == L_G1) ? n0 : n1_reg;
    assign div_start = (state_reg == L_SUM);

    gbs_gini #(.CW(CW)) u_gini (
        .clk   (clk),
        .rst_n (rst_n),
        .start (g_start),
        .c     (g_c),
        .n     (g_n),
        .done  (g_done),
        .imp   (g_imp)
    );

    gbs_div #(.DW(SW), .VW(CW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (SW'(prod1_reg) + SW'(prod0_reg)),
        .divisor  (n_total),
        .done     (div_done),
        .quotient (q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n1_reg <= '0;
            c1_reg <= '0;
        end
        else if (clr)
        begin
            n1_reg <= '0;
            c1_reg <= '0;
        end
        else if (row_beat && feat_bit)
        begin
            if (n1_reg < CW'(MAX_ROWS))
                n1_reg <= n1_reg + 1'b1;
            if (cls_bit && c1_reg < CW'(MAX_ROWS))
                c1_reg <= c1_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            ready_reg <= 1'b0;
            ok_reg    <= 1'b0;
            imp1_reg  <= '0;
            imp0_reg  <= '0;
            prod1_reg <= '0;
            prod0_reg <= '0;
            w_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        ready_reg <= 1'b0;
                        ok_reg    <= (n1_reg != '0) && (n0 != '0);
                        state_reg <= L_G1;
                    end
                end
                L_G1:
                begin
                    if (g_done)
                    begin
                        imp1_reg  <= g_imp;
                        state_reg <= L_G0;
                    end
                end
                L_G0:
                begin
                    if (g_done)
                    begin
                        imp0_reg  <= g_imp;
                        state_reg <= L_M1;
                    end
                end
                L_M1:
                begin
                    prod1_reg <= PW'(n1_reg) * PW'(imp1_reg);
                    state_reg <= L_M0;
                end
                L_M0:
                begin
                    prod0_reg <= PW'(n0) * PW'(imp0_reg);
                    state_reg <= L_SUM;
                end
                L_SUM:
                begin
                    state_reg <= L_DIV;
                end
                L_DIV:
                begin
                    if (div_done)
                    begin
                        w_reg     <= q[GAIN_W-1:0];
                        ready_reg <= 1'b1;
                        state_reg <= L_IDLE;
                    end
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign ready    = ready_reg;
    assign split_ok = ok_reg;
    assign w        = w_reg;
endmodule

// ----- src/gbs_merge.sv -----
// Merge stage: scans lanes in index order, one per cycle, keeps the best split.
// Depends on gbs_pkg.
`timescale 1ns / 1ps
module gbs_merge #(
    parameter int NL = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [NL-1:0]              cand,
    input  logic [NL-1:0]              split_ok,
    input  logic [gbs_pkg::GAIN_W-1:0] w [NL],
    input  logic [gbs_pkg::IMP_W-1:0]  parent,
    output logic                       done,
    output gbs_pkg::split_t            best
);
    import gbs_pkg::*;

    localparam int IW = (NL > 1) ? $clog2(NL) : 1;

    logic              busy_reg, done_reg;
    logic [IW-1:0]     idx_reg, best_idx_reg;
    logic              found_reg, bvalid_reg;
    logic [GAIN_W-1:0] bgain_reg;
    logic [GAIN_W-1:0] par_ext, cur_w, g;
    logic              cur_ok, take;

    assign par_ext = GAIN_W'(parent);
    assign cur_w   = w[idx_reg];
    assign cur_ok  = split_ok[idx_reg];
    assign g       = (par_ext > cur_w) ? par_ext - cur_w : '0;
    assign take    = cand[idx_reg] &&
                     (!found_reg || !bvalid_reg || (cur_ok && g > bgain_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            idx_reg      <= '0;
            best_idx_reg <= '0;
            found_reg    <= 1'b0;
            bvalid_reg   <= 1'b0;
            bgain_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg     <= 1'b1;
            done_reg     <= 1'b0;
            idx_reg      <= '0;
            best_idx_reg <= '0;
            found_reg    <= 1'b0;
            bvalid_reg   <= 1'b0;
            bgain_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                found_reg    <= 1'b1;
                bvalid_reg   <= cur_ok;
                best_idx_reg <= idx_reg;
                bgain_reg    <= cur_ok ? g : '0;
            end
            if (idx_reg == IW'(NL - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done              = done_reg;
    assign best.best_feature = FEAT_IDX_W'(best_idx_reg);
    assign best.found        = found_reg;
    assign best.all_invalid  = found_reg && !bvalid_reg;
    assign best.best_gain    = bgain_reg;
endmodule
